// ===== design/mbsp_pkg.sv =====
package mbsp_pkg;

  // status byte codes
  localparam logic [7:0] REALTIME_FIRST = 8'hf8;
  localparam logic [7:0] SYSEX_START    = 8'hf0;
  localparam logic [7:0] SYSEX_END      = 8'hf7;
  localparam logic [7:0] STATUS_FLAG    = 8'h80;
  localparam logic [7:0] NIBBLE_MASK    = 8'h0f;
  localparam logic [7:0] NO_STATUS      = 8'h00;

  // voice message codes and system common codes that carry data
  localparam logic [7:0] CODE_NOTE_OFF   = 8'h08;
  localparam logic [7:0] CODE_NOTE_ON    = 8'h09;
  localparam logic [7:0] CODE_POLY_PRESS = 8'h0a;
  localparam logic [7:0] CODE_CONTROL    = 8'h0b;
  localparam logic [7:0] CODE_PROGRAM    = 8'h0c;
  localparam logic [7:0] CODE_CHAN_PRESS = 8'h0d;
  localparam logic [7:0] CODE_BEND       = 8'h0e;
  localparam logic [7:0] CODE_TIME_CODE  = 8'hf1;
  localparam logic [7:0] CODE_SONG_POS   = 8'hf2;
  localparam logic [7:0] CODE_SONG_SEL   = 8'hf3;

  // queue between parser and formatter
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // one parsed message as it travels from front to back
  typedef struct packed {
    logic [7:0] status;
    logic [1:0] count;
    logic [6:0] first;
    logic [6:0] second;
  } msg_t;

  // true for channel voice status bytes 80..ef
  function automatic logic is_voice(input logic [7:0] s);
    return s[7] && (s < SYSEX_START);
  endfunction

  // message code: upper nibble for voice, whole byte for system
  function automatic logic [7:0] code_of(input logic [7:0] s);
    logic [7:0] c;
    c = NO_STATUS;
    if (s[7]) begin
      c = (s < SYSEX_START) ? (s >> 4) : s;
    end
    return c;
  endfunction

  // data bytes a status needs
  function automatic logic [1:0] needed_bytes(input logic [7:0] s);
    logic [7:0] c;
    logic [1:0] n;
    c = code_of(s);
    unique case (c)
      CODE_NOTE_OFF, CODE_NOTE_ON, CODE_POLY_PRESS, CODE_CONTROL, CODE_BEND,
      CODE_SONG_POS: n = 2'd2;
      CODE_PROGRAM, CODE_CHAN_PRESS, CODE_TIME_CODE, CODE_SONG_SEL: n = 2'd1;
      default: n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

// ===== design/mbsp_front.sv =====
module mbsp_front import mbsp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] midi_byte,
  output logic       emit,
  output msg_t       msg
);

  logic [7:0] pending_status, pending_status_next;
  logic       skipping_sysex, skipping_sysex_next;
  logic [1:0] received_count, received_count_next;
  logic [6:0] data_first, data_first_next;
  logic [1:0] need;
  logic [1:0] count_inc;

  assign need      = needed_bytes(pending_status);
  assign count_inc = received_count + 2'd1;

  // classify the byte and step the running status state
  always_comb begin
    pending_status_next = pending_status;
    skipping_sysex_next = skipping_sysex;
    received_count_next = received_count;
    data_first_next     = data_first;
    emit                = 1'b0;
    msg                 = '{status: midi_byte, count: 2'd0, first: 7'd0, second: 7'd0};
    priority if (midi_byte >= REALTIME_FIRST) begin
      emit = 1'b1;
    end else if (midi_byte == SYSEX_START) begin
      pending_status_next = midi_byte;
      skipping_sysex_next = 1'b1;
    end else if (midi_byte == SYSEX_END) begin
      pending_status_next = NO_STATUS;
      skipping_sysex_next = 1'b0;
    end else if (midi_byte[7]) begin
      skipping_sysex_next = 1'b0;
      received_count_next = 2'd0;
      if (needed_bytes(midi_byte) == 2'd0) begin
        emit                = 1'b1;
        pending_status_next = NO_STATUS;
      end else begin
        pending_status_next = midi_byte;
      end
    end else if (!skipping_sysex && (received_count < need)) begin
      // data byte that belongs to the pending message
      if (received_count == 2'd0) begin
        data_first_next = midi_byte[6:0];
      end
      received_count_next = count_inc;
      if (count_inc == need) begin
        emit                = 1'b1;
        received_count_next = 2'd0;
        msg.status          = pending_status;
        msg.count           = need;
        if (need == 2'd1) begin
          msg.first = midi_byte[6:0];
        end else begin
          msg.first  = data_first;
          msg.second = midi_byte[6:0];
        end
        if (!is_voice(pending_status)) begin
          pending_status_next = NO_STATUS;
        end
      end
    end
    // stray data bytes fall through with no change
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_status <= NO_STATUS;
      skipping_sysex <= 1'b0;
      received_count <= 2'd0;
    end else if (accept) begin
      pending_status <= pending_status_next;
      skipping_sysex <= skipping_sysex_next;
      received_count <= received_count_next;
    end
  end

  // held data byte, payload only
  always_ff @(posedge clk) begin
    if (accept) begin
      data_first <= data_first_next;
    end
  end

endmodule

// ===== design/mbsp_queue.sv =====
module mbsp_queue import mbsp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_en,
  input  msg_t in_msg,
  input  logic pop_en,
  output msg_t out_msg,
  output logic full,
  output logic empty
);

  msg_t                slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   fill;
  logic                do_push;
  logic                do_pop;

  assign full    = (fill == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push_en && !full;
  assign do_pop  = pop_en && !empty;
  assign out_msg = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= in_msg;
    end
  end

endmodule

// ===== design/mbsp_back.sv =====
module mbsp_back import mbsp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        device_write,
  input  logic [7:0]  device_data,
  input  msg_t        head,
  output logic [7:0]  event_device,
  output logic [7:0]  message_code,
  output logic [3:0]  channel_number,
  output logic [1:0]  data_count,
  output logic [6:0]  data_first,
  output logic [6:0]  data_second,
  output logic [13:0] bend_value
);

  logic [7:0] device_number;

  // device index register
  always_ff @(posedge clk) begin
    if (rst) begin
      device_number <= 8'd0;
    end else if (device_write) begin
      device_number <= device_data;
    end
  end

  // format the head message into result fields
  always_comb begin
    event_device   = device_number;
    message_code   = code_of(head.status);
    channel_number = is_voice(head.status) ? head.status[3:0] & NIBBLE_MASK[3:0] : 4'd0;
    data_count     = head.count;
    data_first     = head.first;
    data_second    = head.second;
    bend_value     = (message_code == CODE_BEND) ? {head.second, head.first} : 14'd0;
  end

endmodule

// ===== design/midi_byte_stream_parser_top.sv =====
// result path: the event completed by an accepted byte is registered in the event
// queue at that edge; queue head to result ports is combinational
// throughput: one byte per cycle while full is low; full rises only when the
// four-entry event queue between parser and formatter holds four unread words
// reset (rst, synchronous): clears the pending status, sysex flag, data count,
// queue and device number
module midi_byte_stream_parser_top import mbsp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  midi_byte,
  input  logic        device_write,
  input  logic [7:0]  device_data,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  event_device,
  output logic [7:0]  message_code,
  output logic [3:0]  channel_number,
  output logic [1:0]  data_count,
  output logic [6:0]  data_first,
  output logic [6:0]  data_second,
  output logic [13:0] bend_value
);

  logic accept;
  logic emit;
  msg_t parsed;
  msg_t head;

  assign accept = push && !full;

  // byte parser
  mbsp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .midi_byte (midi_byte),
    .emit      (emit),
    .msg       (parsed)
  );

  // event queue
  mbsp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push_en (accept && emit),
    .in_msg  (parsed),
    .pop_en  (pop),
    .out_msg (head),
    .full    (full),
    .empty   (empty)
  );

  // result formatter
  mbsp_back u_back (
    .clk            (clk),
    .rst            (rst),
    .device_write   (device_write),
    .device_data    (device_data),
    .head           (head),
    .event_device   (event_device),
    .message_code   (message_code),
    .channel_number (channel_number),
    .data_count     (data_count),
    .data_first     (data_first),
    .data_second    (data_second),
    .bend_value     (bend_value)
  );

endmodule

// ===== design/mbsp_checker.sv =====
module mbsp_checker import mbsp_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        push,
  input logic        full,
  input logic [7:0]  midi_byte,
  input logic        empty,
  input logic [7:0]  message_code,
  input logic [3:0]  channel_number,
  input logic [1:0]  data_count,
  input logic [6:0]  data_second,
  input logic [13:0] bend_value
);

  // reset leaves no word waiting
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  // a real-time byte into an idle block is ready next cycle
  a_realtime: assert property (@(posedge clk) disable iff (rst)
    (push && !full && (midi_byte >= REALTIME_FIRST) && empty) |=> !empty)
    else $error("real-time byte produced no word");

  // channel only on voice codes
  a_channel: assert property (@(posedge clk) disable iff (rst)
    (!empty && (channel_number != 4'd0)) |->
      ((message_code >= CODE_NOTE_OFF) && (message_code <= CODE_BEND)))
    else $error("channel on a system message");

  // bend only on pitch bend with two data bytes
  a_bend: assert property (@(posedge clk) disable iff (rst)
    (!empty && (bend_value != 14'd0)) |->
      ((message_code == CODE_BEND) && (data_count == 2'd2)))
    else $error("bend value on a non-bend word");

  // second data byte only when two are carried
  a_second: assert property (@(posedge clk) disable iff (rst)
    (!empty && (data_second != 7'd0)) |-> (data_count == 2'd2))
    else $error("second data byte without a count of two");

endmodule

bind midi_byte_stream_parser_top mbsp_checker u_mbsp_checker (.*);
